@@ rtl/wrm_pkg.sv @@
// wrm_pkg: shared widths, reset values, codes and sequencer states
// of the windowed event rate meter; no dependencies
`default_nettype none

package wrm_pkg;

  localparam int unsigned TS_W       = 32;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned MS_W       = 10;
  localparam int unsigned NUM_W      = COUNT_W + MS_W;
  localparam int unsigned WIN_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [MS_W-1:0]    MS_PER_SEC      = 10'd1000;
  localparam logic [WIN_W-1:0]   INITIAL_WIN_RST = 16'd100;
  localparam logic [WIN_W-1:0]   UPDATE_WIN_RST  = 16'd1000;
  localparam logic [COUNT_W-1:0] COUNT_MAX       = {COUNT_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REPORT_EN   = 2'd0,
    CFG_INITIAL_WIN = 2'd1,
    CFG_UPDATE_WIN  = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    REQ_RESTART = 1'b0,
    REQ_FRAME   = 1'b1
  } req_type_e;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_EVAL  = 6'b000010,
    ST_MUL   = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_ROUND = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_e;

endpackage

`default_nettype wire

@@ rtl/wrm_if.sv @@
// wrm_req_if and wrm_rsp_if: valid/ready channels of the rate meter
// depends on wrm_pkg for the timestamp width
`default_nettype none

interface wrm_req_if
  import wrm_pkg::*;
;
  logic            valid;
  logic            ready;
  logic            req_type;
  logic [TS_W-1:0] timestamp_ms;

  modport source (output valid, output req_type, output timestamp_ms, input ready);
  modport sink   (input valid, input req_type, input timestamp_ms, output ready);
endinterface

interface wrm_rsp_if #(
  parameter int unsigned RATE_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [RATE_BITS-1:0] current_rate;
  logic                 rate_updated;

  modport source (output valid, output current_rate, output rate_updated, input ready);
  modport sink   (input valid, input current_rate, input rate_updated, output ready);
endinterface

`default_nettype wire

@@ rtl/wrm_divider.sv @@
// wrm_divider: restoring divider, one quotient bit per cycle
// no package dependency
`default_nettype none

module wrm_divider #(
  parameter int unsigned NUM_W = 42,
  parameter int unsigned DEN_W = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic [NUM_W-1:0]      quot_o,
  output logic [DEN_W-1:0]      rem_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;

  logic [DEN_W:0] rem_sh;
  logic [DEN_W:0] diff;
  logic           fits;

  // shift the next dividend bit into the partial remainder and try a subtract
  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign fits   = !diff[DEN_W];

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = '0;
      num_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      num_d = {num_q[NUM_W-2:0], fits};
      rem_d = fits ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = num_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

@@ rtl/windowed_event_rate_meter_unit.sv @@
// windowed_event_rate_meter_unit: top level, sequencer, state and config registers
// depends on wrm_pkg, wrm_if and wrm_divider
`default_nettype none

// Windowed event rate meter. Each request beat is either a restart (req_type 0)
// or one frame event (req_type 1) stamped with a millisecond time that wraps.
// A restart clears the frame count, opens a window at its timestamp, re-enters
// the initial phase and returns rate 0. A frame bumps the saturating count and,
// when reporting is enabled and the elapsed time reaches the initial window
// (first report) or the update window (later reports), computes
// round_half_up(frames * 1000 / elapsed), saturated to RATE_BITS. The first
// report keeps the window open; later ones restart it at the frame's time.
// Every request gives exactly one response beat with the rate after that item
// and a flag telling whether it was freshly computed. Items are handled one at
// a time: a restart or a non-reporting frame goes from ST_EVAL to ST_EMIT,
// a reporting frame first passes ST_MUL, ST_DIV (the bit-serial divider, one
// quotient bit per cycle, 42-bit numerator frames * 1000) and ST_ROUND. The
// next request is taken once the response is in the output register, even if
// the sink has not yet taken it. Config writes (cfg_we_i, cfg_idx_i,
// cfg_wdata_i) take effect the next cycle and are meant for idle periods;
// unknown indexes are dropped. A window register of 0 acts as 1 ms.
module windowed_event_rate_meter_unit
  import wrm_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32,
  parameter int unsigned RATE_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  wrm_req_if.sink                    req_i,
  wrm_rsp_if.source                  rsp_o
);

  localparam logic [NUM_W:0] RATE_MAX_W = (NUM_W + 1)'({RATE_BITS{1'b1}});

  // config registers
  logic             report_en_q, report_en_d;
  logic [WIN_W-1:0] initial_win_q, initial_win_d;
  logic [WIN_W-1:0] update_win_q, update_win_d;

  // measurement state
  state_e               state_q, state_d;
  logic [COUNT_W-1:0]   frame_count_q, frame_count_d;
  logic [TIME_BITS-1:0] window_start_q, window_start_d;
  logic                 initial_phase_q, initial_phase_d;
  logic [RATE_BITS-1:0] rate_value_q, rate_value_d;

  // per-item working registers
  logic                 kind_q, kind_d;
  logic [TIME_BITS-1:0] now_q, now_d;
  logic [TIME_BITS-1:0] elapsed_q, elapsed_d;
  logic                 upd_q, upd_d;

  // output register
  logic                 rsp_valid_q, rsp_valid_d;
  logic [RATE_BITS-1:0] rsp_rate_q, rsp_rate_d;
  logic                 rsp_upd_q, rsp_upd_d;

  logic                 req_acc;
  logic [TIME_BITS-1:0] elapsed;
  logic [WIN_W-1:0]     target;
  logic [WIN_W-1:0]     target_nz;
  logic                 due;
  logic                 out_free;

  // divider hookup
  logic                 div_start;
  logic [NUM_W-1:0]     div_num;
  logic                 div_done;
  logic [NUM_W-1:0]     div_quot;
  logic [TIME_BITS-1:0] div_rem;

  // rounding and saturation of the quotient
  logic                 round_up;
  logic [NUM_W:0]       q_rnd;
  logic [RATE_BITS-1:0] rate_new;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign out_free    = !rsp_valid_q || rsp_o.ready;

  // elapsed time wraps with the timestamp width, a zero window counts as 1 ms
  assign elapsed   = now_q - window_start_q;
  assign target    = initial_phase_q ? initial_win_q : update_win_q;
  assign target_nz = (target == '0) ? WIN_W'(1) : target;
  assign due       = report_en_q && (elapsed >= TIME_BITS'(target_nz));

  // frames * 1000 feeds straight into the divider's dividend register
  assign div_start = (state_q == ST_MUL);
  assign div_num   = NUM_W'(frame_count_q) * NUM_W'(MS_PER_SEC);

  wrm_divider #(
    .NUM_W (NUM_W),
    .DEN_W (TIME_BITS)
  ) u_wrm_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (elapsed_q),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  // half up: bump when twice the remainder reaches the divisor
  assign round_up = {div_rem, 1'b0} >= {1'b0, elapsed_q};
  assign q_rnd    = {1'b0, div_quot} + (NUM_W + 1)'(round_up);
  assign rate_new = (q_rnd > RATE_MAX_W) ? {RATE_BITS{1'b1}} : q_rnd[RATE_BITS-1:0];

  always_comb begin
    report_en_d     = report_en_q;
    initial_win_d   = initial_win_q;
    update_win_d    = update_win_q;
    state_d         = state_q;
    frame_count_d   = frame_count_q;
    window_start_d  = window_start_q;
    initial_phase_d = initial_phase_q;
    rate_value_d    = rate_value_q;
    kind_d          = kind_q;
    now_d           = now_q;
    elapsed_d       = elapsed_q;
    upd_d           = upd_q;
    rsp_valid_d     = rsp_valid_q && !rsp_o.ready;
    rsp_rate_d      = rsp_rate_q;
    rsp_upd_d       = rsp_upd_q;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_REPORT_EN:   report_en_d   = cfg_wdata_i[0];
        CFG_INITIAL_WIN: initial_win_d = cfg_wdata_i[WIN_W-1:0];
        CFG_UPDATE_WIN:  update_win_d  = cfg_wdata_i[WIN_W-1:0];
        default:         ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          kind_d  = req_i.req_type;
          now_d   = TIME_BITS'(req_i.timestamp_ms);
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        upd_d = 1'b0;
        if (kind_q == REQ_RESTART) begin
          frame_count_d   = '0;
          window_start_d  = now_q;
          initial_phase_d = 1'b1;
          rate_value_d    = '0;
          state_d         = ST_EMIT;
        end else begin
          if (frame_count_q != COUNT_MAX) begin
            frame_count_d = frame_count_q + 1'b1;
          end
          elapsed_d = elapsed;
          state_d   = due ? ST_MUL : ST_EMIT;
        end
      end
      ST_MUL: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        rate_value_d = rate_new;
        upd_d        = 1'b1;
        // first report keeps the window, later ones open a fresh one
        if (initial_phase_q) begin
          initial_phase_d = 1'b0;
        end else begin
          window_start_d = now_q;
          frame_count_d  = '0;
        end
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          rsp_valid_d = 1'b1;
          rsp_rate_d  = rate_value_q;
          rsp_upd_d   = upd_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      report_en_q     <= 1'b1;
      initial_win_q   <= INITIAL_WIN_RST;
      update_win_q    <= UPDATE_WIN_RST;
      state_q         <= ST_IDLE;
      frame_count_q   <= '0;
      window_start_q  <= '0;
      initial_phase_q <= 1'b1;
      rate_value_q    <= '0;
      rsp_valid_q     <= 1'b0;
    end else begin
      report_en_q     <= report_en_d;
      initial_win_q   <= initial_win_d;
      update_win_q    <= update_win_d;
      state_q         <= state_d;
      frame_count_q   <= frame_count_d;
      window_start_q  <= window_start_d;
      initial_phase_q <= initial_phase_d;
      rate_value_q    <= rate_value_d;
      rsp_valid_q     <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    now_q      <= now_d;
    elapsed_q  <= elapsed_d;
    upd_q      <= upd_d;
    rsp_rate_q <= rsp_rate_d;
    rsp_upd_q  <= rsp_upd_d;
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.current_rate = rsp_rate_q;
  assign rsp_o.rate_updated = rsp_upd_q;

endmodule

`default_nettype wire

@@ rtl/wrm_checker.sv @@
// wrm_checker: port-level assertions for the rate meter, bound to the top level
// depends on windowed_event_rate_meter_unit and its channel interfaces
`default_nettype none

module wrm_checker #(
  parameter int unsigned RATE_BITS = 16
) (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 req_valid_i,
  input wire logic                 req_ready_i,
  input wire logic                 rsp_valid_i,
  input wire logic                 rsp_ready_i,
  input wire logic [RATE_BITS-1:0] rsp_rate_i,
  input wire logic                 rsp_upd_i
);

  // one item at a time: no request beat right behind an accepted one
  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i
  ) else $error("request ready right after an accepted beat");

  // a stalled response beat holds
  a_rsp_hold: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_rate_i) && $stable(rsp_upd_i)
  ) else $error("response beat changed while stalled");

  // a new response only rises after item work, never straight out of idle
  a_rsp_from_work: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> !$past(req_ready_i)
  ) else $error("response raised without item in flight");

endmodule

bind windowed_event_rate_meter_unit wrm_checker #(
  .RATE_BITS (RATE_BITS)
) u_wrm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_rate_i  (rsp_o.current_rate),
  .rsp_upd_i   (rsp_o.rate_updated)
);

`default_nettype wire
